/* rtl/smrg_pkg.sv */
// Shared types, codes and key helper for the sparse key sorted merge block.
package smrg_pkg;

	localparam logic [2:0] OP_CLEAR        = 3'd0;
	localparam logic [2:0] OP_APPEND_OWN   = 3'd1;
	localparam logic [2:0] OP_APPEND_OTHER = 3'd2;
	localparam logic [2:0] OP_MERGE        = 3'd3;
	localparam logic [2:0] OP_READ_OWN     = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVER_CAP = 2'd1;
	localparam logic [1:0] ST_BAD_IDX  = 2'd2;

	localparam logic [10:0] CAP_RESET = 11'd1024;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] entry_value;
		logic [9:0]  read_index;
	} smrg_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [10:0] own_size;
		logic [31:0] read_value;
	} smrg_result_t;

	// Odd words carry their key from bit 7 upwards, even words from bit 1 upwards.
	function automatic logic [30:0] key_of(input logic [31:0] w);
		logic [30:0] k;
		if (w[0]) begin
			k = {6'd0, w[31:7]};
		end else begin
			k = w[31:1];
		end
		return k;
	endfunction

endpackage

/* rtl/smrg_ram.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
module smrg_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

/* rtl/sparse_key_sorted_merge.sv */
// Top level of the sparse key sorted merge block: control, counts and list memories.
//
//  channel  | signals                        | direction | payload
//  ---------+--------------------------------+-----------+------------------------
//  item     | item_valid, item_ready, item   | in        | op, entry_value, index
//  result   | result_valid, result_ready,    | out       | status, own_size,
//           | result                         |           | read_value
//  cfg      | cfg_valid, cfg_ready, cfg_data | in        | capacity_in_use
//
// Clear, append and unused codes are done as they are accepted; a read of the own
// list waits for one registered RAM read. A merge primes the RAM reads as it is
// accepted, writes at most capacity merged entries to the scratch bank and then
// closes; the merge loop writes one scratch word per cycle.
// Reset clears counts, bank select, capacity (to 1024) and the handshakes; list
// memories are not cleared. A result that meets a still occupied output register
// is parked in a holding register, and item_ready stays low until it moves up.
module sparse_key_sorted_merge #(
	parameter int MAX_ENTRIES = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  smrg_pkg::smrg_item_t  item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output smrg_pkg::smrg_result_t result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [10:0]           cfg_data
);

	// Count width holds MAX_ENTRIES itself; address width indexes the memories.
	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int AW   = $clog2(MAX_ENTRIES);
	localparam int CMPW = (CW > 11) ? CW : 11;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_READ  = 2'd1;
	localparam logic [1:0] S_MERGE = 2'd2;
	localparam logic [1:0] S_HOLD  = 2'd3;

	logic [1:0]    state_q, state_d;
	logic          sel_q, sel_d;        // bank holding the own list
	logic [CW-1:0] own_cnt_q, own_cnt_d;
	logic [CW-1:0] oth_cnt_q, oth_cnt_d;
	logic [CW-1:0] i_q, i_d, j_q, j_d, n_q, n_d;
	logic [10:0]   cap_q;

	logic                   out_valid_q;
	smrg_pkg::smrg_result_t out_q;
	smrg_pkg::smrg_result_t hold_q;
	smrg_pkg::smrg_result_t res;
	logic                   res_fire;
	logic                   slot_free;

	logic [CMPW-1:0] cap_ext, max_ext, cap_lim;
	logic [CMPW-1:0] own_ext, oth_ext, n_ext, idx_ext;

	// Role-based memory ports, mapped onto the two banks by sel_q.
	logic          own_wr_en, scr_wr_en, oth_wr_en;
	logic [AW-1:0] own_wr_addr, scr_wr_addr, oth_wr_addr;
	logic [31:0]   own_wr_data, scr_wr_data, oth_wr_data;
	logic [AW-1:0] own_rd_addr, oth_rd_addr;
	logic [31:0]   own_rd_data, oth_rd_data;

	logic          b0_wr_en, b1_wr_en;
	logic [AW-1:0] b0_wr_addr, b1_wr_addr;
	logic [31:0]   b0_wr_data, b1_wr_data;
	logic [31:0]   b0_rd_data, b1_rd_data;

	logic        i_more, j_more;
	logic [31:0] a_word, b_word, w_word;

	assign item_ready   = (state_q == S_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign slot_free    = !out_valid_q || result_ready;

	// Limit the capacity in use to the storage depth.
	assign cap_ext = CMPW'(cap_q);
	assign max_ext = CMPW'(MAX_ENTRIES);
	assign cap_lim = (cap_ext > max_ext) ? max_ext : cap_ext;
	assign own_ext = CMPW'(own_cnt_q);
	assign oth_ext = CMPW'(oth_cnt_q);
	assign n_ext   = CMPW'(n_q);
	assign idx_ext = CMPW'(item.read_index);

	assign a_word = own_rd_data;
	assign b_word = oth_rd_data;
	assign i_more = (i_q < own_cnt_q);
	assign j_more = (j_q < oth_cnt_q);

	always_comb begin
		state_d     = state_q;
		sel_d       = sel_q;
		own_cnt_d   = own_cnt_q;
		oth_cnt_d   = oth_cnt_q;
		i_d         = i_q;
		j_d         = j_q;
		n_d         = n_q;
		res_fire    = 1'b0;
		res         = '0;
		w_word      = a_word;
		own_wr_en   = 1'b0;
		own_wr_addr = own_cnt_q[AW-1:0];
		own_wr_data = item.entry_value;
		oth_wr_en   = 1'b0;
		oth_wr_addr = oth_cnt_q[AW-1:0];
		oth_wr_data = item.entry_value;
		scr_wr_en   = 1'b0;
		scr_wr_addr = n_q[AW-1:0];
		scr_wr_data = a_word;
		own_rd_addr = i_q[AW-1:0];
		oth_rd_addr = j_q[AW-1:0];

		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					res_fire        = 1'b1;
					res.status      = smrg_pkg::ST_OK;
					res.own_size    = own_ext[10:0];
					case (item.op)
						smrg_pkg::OP_CLEAR: begin
							own_cnt_d    = '0;
							oth_cnt_d    = '0;
							res.own_size = '0;
						end
						smrg_pkg::OP_APPEND_OWN: begin
							if (own_ext >= cap_lim) begin
								res.status = smrg_pkg::ST_OVER_CAP;
							end else begin
								own_wr_en    = 1'b1;
								own_cnt_d    = own_cnt_q + CW'(1);
								res.own_size = 11'(own_ext + CMPW'(1));
							end
						end
						smrg_pkg::OP_APPEND_OTHER: begin
							if (oth_ext >= cap_lim) begin
								res.status = smrg_pkg::ST_OVER_CAP;
							end else begin
								oth_wr_en = 1'b1;
								oth_cnt_d = oth_cnt_q + CW'(1);
							end
						end
						smrg_pkg::OP_MERGE: begin
							if (own_cnt_q == '0 && oth_cnt_q == '0) begin
								// Nothing to walk: succeed at once with an empty list.
								sel_d = !sel_q;
							end else begin
								res_fire    = 1'b0;
								i_d         = '0;
								j_d         = '0;
								n_d         = '0;
								own_rd_addr = '0;
								oth_rd_addr = '0;
								state_d     = S_MERGE;
							end
						end
						smrg_pkg::OP_READ_OWN: begin
							if (idx_ext >= own_ext) begin
								res.status = smrg_pkg::ST_BAD_IDX;
							end else begin
								res_fire    = 1'b0;
								own_rd_addr = idx_ext[AW-1:0];
								state_d     = S_READ;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
				res_fire       = 1'b1;
				res.status     = smrg_pkg::ST_OK;
				res.own_size   = own_ext[10:0];
				res.read_value = own_rd_data;
				state_d        = S_IDLE;
			end
			S_MERGE: begin
				if (!i_more && !j_more) begin
					// Both lists drained: the scratch bank becomes the own list.
					res_fire     = 1'b1;
					res.status   = smrg_pkg::ST_OK;
					res.own_size = n_ext[10:0];
					sel_d        = !sel_q;
					own_cnt_d    = n_q;
					oth_cnt_d    = '0;
					state_d      = S_IDLE;
				end else if (n_ext >= cap_lim) begin
					// Drop the scratch contents; both lists stay as they were.
					res_fire     = 1'b1;
					res.status   = smrg_pkg::ST_OVER_CAP;
					res.own_size = own_ext[10:0];
					state_d      = S_IDLE;
				end else begin
					if (!j_more) begin
						w_word = a_word;
						i_d    = i_q + CW'(1);
					end else if (!i_more) begin
						w_word = b_word;
						j_d    = j_q + CW'(1);
					end else if (smrg_pkg::key_of(a_word) == smrg_pkg::key_of(b_word)) begin
						w_word = (a_word < b_word) ? a_word : b_word;
						i_d    = i_q + CW'(1);
						j_d    = j_q + CW'(1);
					end else if (a_word < b_word) begin
						w_word = a_word;
						i_d    = i_q + CW'(1);
					end else begin
						w_word = b_word;
						j_d    = j_q + CW'(1);
					end
					scr_wr_en   = 1'b1;
					scr_wr_data = w_word;
					n_d         = n_q + CW'(1);
					// Advance the read addresses so next cycle sees the new heads.
					own_rd_addr = i_d[AW-1:0];
					oth_rd_addr = j_d[AW-1:0];
				end
			end
			S_HOLD: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Park the result when the output register is still occupied.
		if (res_fire && !slot_free) begin
			state_d = S_HOLD;
		end
	end

	// Bank mapping: the own list lives in bank 1 when sel_q is set.
	always_comb begin
		if (sel_q) begin
			b1_wr_en    = own_wr_en;
			b1_wr_addr  = own_wr_addr;
			b1_wr_data  = own_wr_data;
			b0_wr_en    = scr_wr_en;
			b0_wr_addr  = scr_wr_addr;
			b0_wr_data  = scr_wr_data;
			own_rd_data = b1_rd_data;
		end else begin
			b0_wr_en    = own_wr_en;
			b0_wr_addr  = own_wr_addr;
			b0_wr_data  = own_wr_data;
			b1_wr_en    = scr_wr_en;
			b1_wr_addr  = scr_wr_addr;
			b1_wr_data  = scr_wr_data;
			own_rd_data = b0_rd_data;
		end
	end

	smrg_ram #(
		.DEPTH (MAX_ENTRIES),
		.WIDTH (32)
	) u_bank0 (
		.clk     (clk),
		.wr_en   (b0_wr_en),
		.wr_addr (b0_wr_addr),
		.wr_data (b0_wr_data),
		.rd_addr (own_rd_addr),
		.rd_data (b0_rd_data)
	);

	smrg_ram #(
		.DEPTH (MAX_ENTRIES),
		.WIDTH (32)
	) u_bank1 (
		.clk     (clk),
		.wr_en   (b1_wr_en),
		.wr_addr (b1_wr_addr),
		.wr_data (b1_wr_data),
		.rd_addr (own_rd_addr),
		.rd_data (b1_rd_data)
	);

	smrg_ram #(
		.DEPTH (MAX_ENTRIES),
		.WIDTH (32)
	) u_other (
		.clk     (clk),
		.wr_en   (oth_wr_en),
		.wr_addr (oth_wr_addr),
		.wr_data (oth_wr_data),
		.rd_addr (oth_rd_addr),
		.rd_data (oth_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_q       <= 1'b0;
			own_cnt_q   <= '0;
			oth_cnt_q   <= '0;
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			cap_q       <= smrg_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			sel_q     <= sel_d;
			own_cnt_q <= own_cnt_d;
			oth_cnt_q <= oth_cnt_d;
			i_q       <= i_d;
			j_q       <= j_d;
			n_q       <= n_d;
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if ((res_fire || state_q == S_HOLD) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: output slot and holding register.
	always_ff @(posedge clk) begin
		if (state_q == S_HOLD && slot_free) begin
			out_q <= hold_q;
		end else if (res_fire && slot_free) begin
			out_q <= res;
		end
		if (res_fire && !slot_free) begin
			hold_q <= res;
		end
	end

endmodule

/* tb/tb.sv */
// Self-checking testbench for the sparse key sorted merge block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import smrg_pkg::*;

	// Depth of each list memory, as built into the block by default
	localparam int DEPTH = 1024;
	// Live transactions wanted from the random part
	localparam int RANDOM_ITEMS = 170;
	// Cycles to let pass once nothing is outstanding; covers the closing merge cycle
	localparam int SETTLE_CYCLES = 16;
	// Longest correct silence is one full-depth merge plus a result stall and an
	// item gap; allow several times that
	localparam int QUIET_LIMIT = 12000;

	// Op codes the block leaves alone
	localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
	localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

	logic         clk;
	logic         arst_n;
	logic         item_valid;
	logic         item_ready;
	smrg_item_t   item;
	logic         result_valid;
	logic         result_ready;
	smrg_result_t result;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [10:0]  cfg_data;

	sparse_key_sorted_merge dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// Our own picture of the block: both lists, their lengths and the capacity
	logic [31:0]  own_words [DEPTH];
	logic [31:0]  other_words [DEPTH];
	int unsigned  own_len;
	int unsigned  other_len;
	logic [10:0]  cap_setting;

	// Results owed by the block, oldest first
	smrg_result_t expected_results [$];

	bit           idle_on;
	int unsigned  fail_count      = 0;
	int unsigned  items_sent      = 0;
	int unsigned  live_items      = 0;
	int unsigned  results_seen    = 0;
	int unsigned  merges_sent     = 0;
	int unsigned  merge_overflows = 0;
	int unsigned  cap_writes      = 0;
	int unsigned  quiet_cycles    = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Odd words keep their key from bit 7 upwards, even words from bit 1
	function automatic logic [30:0] word_key(input logic [31:0] w);
		return w[0] ? {6'd0, w[31:7]} : w[31:1];
	endfunction

	// Capacity actually in force: never more than the memory depth
	function automatic int unsigned list_limit();
		return (cap_setting > DEPTH) ? DEPTH : cap_setting;
	endfunction

	// Apply one transaction to the local lists and return what the block owes
	function automatic smrg_result_t next_result(input smrg_item_t it);
		smrg_result_t r;
		logic [31:0]  merged [DEPTH];
		logic [31:0]  a;
		logic [31:0]  b;
		logic [31:0]  w;
		int unsigned  i;
		int unsigned  j;
		int unsigned  n;
		int unsigned  lim;
		bit           overflow;
		r = '0;
		r.status = ST_OK;
		lim = list_limit();
		case (it.op)
			OP_CLEAR: begin
				own_len = 0;
				other_len = 0;
			end
			OP_APPEND_OWN: begin
				if (own_len >= lim) begin
					r.status = ST_OVER_CAP;
				end else begin
					own_words[own_len] = it.entry_value;
					own_len++;
				end
			end
			OP_APPEND_OTHER: begin
				if (other_len >= lim) begin
					r.status = ST_OVER_CAP;
				end else begin
					other_words[other_len] = it.entry_value;
					other_len++;
				end
			end
			OP_MERGE: begin
				merges_sent++;
				i = 0;
				j = 0;
				n = 0;
				overflow = 1'b0;
				// Walk both heads; equal keys collapse into the smaller word
				while (!overflow && (i < own_len || j < other_len)) begin
					if (n >= lim) begin
						overflow = 1'b1;
					end else begin
						if (j >= other_len) begin
							w = own_words[i];
							i++;
						end else if (i >= own_len) begin
							w = other_words[j];
							j++;
						end else begin
							a = own_words[i];
							b = other_words[j];
							if (word_key(a) == word_key(b)) begin
								w = (a < b) ? a : b;
								i++;
								j++;
							end else if (a < b) begin
								w = a;
								i++;
							end else begin
								w = b;
								j++;
							end
						end
						merged[n] = w;
						n++;
					end
				end
				if (overflow) begin
					// Leave both lists as they were
					r.status = ST_OVER_CAP;
					merge_overflows++;
				end else begin
					for (int k = 0; k < n; k++) begin
						own_words[k] = merged[k];
					end
					own_len = n;
					other_len = 0;
				end
			end
			OP_READ_OWN: begin
				if (it.read_index >= own_len) begin
					r.status = ST_BAD_IDX;
				end else begin
					r.read_value = own_words[it.read_index];
				end
			end
			default: begin
			end
		endcase
		r.own_size = 11'(own_len);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result side: random stalls on ready, and the checker
	// ------------------------------------------------------------------

	initial begin : result_sink
		int unsigned stall_left;
		stall_left = 0;
		result_ready = 1'b1;
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				// Hold ready low until the burst runs out
				stall_left--;
				if (stall_left == 0) begin
					result_ready <= 1'b1;
				end
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 12);
				result_ready <= 1'b0;
			end
		end
	end

	// Compare every accepted result with the oldest one owed
	always @(posedge clk) begin : result_check
		smrg_result_t owed;
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("result with no transaction outstanding: status %0d own_size %0d value %h",
					result.status, result.own_size, result.read_value);
				fail_count++;
			end else begin
				owed = expected_results.pop_front();
				if (result.status !== owed.status) begin
					$error("status: expected %0d, actual %0d", owed.status, result.status);
					fail_count++;
				end
				if (result.own_size !== owed.own_size) begin
					$error("own_size: expected %0d, actual %0d", owed.own_size, result.own_size);
					fail_count++;
				end
				if (result.read_value !== owed.read_value) begin
					$error("read_value: expected %h, actual %h", owed.read_value,
						result.read_value);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: end the run if no transaction moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$error("no transaction for %0d cycles, %0d results still owed",
				quiet_cycles, expected_results.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Shared drivers
	// ------------------------------------------------------------------

	// Offer one transaction and record what it should produce once taken.
	// Valid is left high on return so a following item can go straight out;
	// it is only dropped at the start of a gap or when the stream pauses.
	task automatic send_item(input logic [2:0] op, input logic [31:0] value,
			input logic [9:0] index);
		smrg_item_t it;
		it.op = op;
		it.entry_value = value;
		it.read_index = index;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		expected_results.push_back(next_result(it));
		items_sent++;
		if (op <= OP_READ_OWN) begin
			live_items++;
		end
	endtask

	// Drop valid, wait for every owed result, then let the block settle
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Capacity may only change while the block has nothing in flight
	task automatic write_capacity(input logic [10:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cap_setting = value;
		cap_writes++;
	endtask

	// Bias words towards small values so that odd and even keys collide often
	function automatic logic [31:0] random_word();
		logic [31:0] w;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: w = $urandom_range(0, 255);
			4, 5, 6:    w = $urandom_range(0, 8191) | 32'd1;
			7:          w = 32'($urandom_range(0, 63)) << 1;
			default:    w = $urandom();
		endcase
		return w;
	endfunction

	// Append a list of random words in ascending order, now and then out of order
	task automatic append_sorted(input logic [2:0] op, input int unsigned count);
		logic [31:0] vals [24];
		logic [31:0] w;
		int unsigned k;
		int unsigned m;
		for (k = 0; k < count; k++) begin
			w = random_word();
			m = k;
			while (m > 0 && vals[m - 1] > w) begin
				vals[m] = vals[m - 1];
				m--;
			end
			vals[m] = w;
		end
		if (count > 1 && $urandom_range(0, 7) == 0) begin
			w = vals[0];
			vals[0] = vals[count - 1];
			vals[count - 1] = w;
		end
		for (k = 0; k < count; k++) begin
			send_item(op, vals[k], 10'($urandom()));
		end
	endtask

	// Read the own list, mostly near its length, sometimes anywhere
	task automatic read_some(input int unsigned count);
		repeat (count) begin
			if ($urandom_range(0, 3) == 0) begin
				send_item(OP_READ_OWN, $urandom(), 10'($urandom_range(0, DEPTH - 1)));
			end else begin
				send_item(OP_READ_OWN, $urandom(), 10'($urandom_range(0, own_len + 1)));
			end
		end
	endtask

	// One well-formed round: optional clear, fill both lists, merge, read back
	task automatic run_merge_sequence();
		int unsigned span;
		span = (list_limit() > 16) ? 16 : list_limit();
		if ($urandom_range(0, 4) != 0) begin
			send_item(OP_CLEAR, $urandom(), 10'($urandom()));
		end
		append_sorted(OP_APPEND_OWN, $urandom_range(0, span + 2));
		append_sorted(OP_APPEND_OTHER, $urandom_range(0, span + 2));
		// Sprinkle ignored codes and stray reads into the stream
		repeat ($urandom_range(0, 2)) begin
			if ($urandom_range(0, 1) == 0) begin
				send_item(3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)),
					$urandom(), 10'($urandom()));
			end else begin
				read_some(1);
			end
		end
		send_item(OP_MERGE, $urandom(), 10'($urandom()));
		read_some($urandom_range(1, 4));
		// Occasionally merge again, with the other list emptied unless the first merge overflowed
		if ($urandom_range(0, 5) == 0) begin
			send_item(OP_MERGE, $urandom(), 10'($urandom()));
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Extreme words, equal keys, every op and reads out of range, at reset capacity
	task automatic test_directed();
		send_item(OP_READ_OWN, 32'h0000_0000, 10'd0);
		send_item(OP_APPEND_OWN, 32'h0000_0000, 10'h3FF);
		send_item(OP_APPEND_OWN, 32'h0000_4001, 10'h000);
		send_item(OP_APPEND_OWN, 32'hFFFF_FFFF, 10'h3FF);
		// 0x100 is even with the same key as the odd 0x4001: written once, as 0x100
		send_item(OP_APPEND_OTHER, 32'h0000_0100, 10'h000);
		send_item(OP_APPEND_OTHER, 32'hFFFF_FFFE, 10'h3FF);
		send_item(OP_MERGE, 32'hFFFF_FFFF, 10'h3FF);
		for (int k = 0; k < 4; k++) begin
			send_item(OP_READ_OWN, 32'hFFFF_FFFF, 10'(k));
		end
		send_item(OP_READ_OWN, 32'h0000_0000, 10'd4);
		send_item(OP_READ_OWN, 32'h0000_0000, 10'h3FF);
		for (int c = OP_FIRST_UNUSED; c <= OP_LAST_UNUSED; c++) begin
			send_item(3'(c), 32'hFFFF_FFFF, 10'h3FF);
		end
		send_item(OP_CLEAR, 32'hFFFF_FFFF, 10'h3FF);
		send_item(OP_READ_OWN, 32'h0000_0000, 10'd0);
	endtask

	// Capacity of one and of zero: full lists, merge overflow, empty merge
	task automatic test_capacity_edges();
		write_capacity(11'd1);
		send_item(OP_CLEAR, 32'h0, 10'd0);
		send_item(OP_APPEND_OWN, 32'h0000_0010, 10'd0);
		send_item(OP_APPEND_OWN, 32'h0000_0020, 10'd0);
		send_item(OP_APPEND_OTHER, 32'h0000_0041, 10'd0);
		send_item(OP_MERGE, 32'h0, 10'd0);
		send_item(OP_READ_OWN, 32'h0, 10'd0);
		// Keys match, so the merged list still fits in one entry
		send_item(OP_CLEAR, 32'h0, 10'd0);
		send_item(OP_APPEND_OWN, 32'h0000_0081, 10'd0);
		send_item(OP_APPEND_OTHER, 32'h0000_0002, 10'd0);
		send_item(OP_MERGE, 32'h0, 10'd0);
		send_item(OP_READ_OWN, 32'h0, 10'd0);
		write_capacity(11'd0);
		send_item(OP_APPEND_OWN, 32'h0000_0005, 10'd0);
		send_item(OP_CLEAR, 32'h0, 10'd0);
		send_item(OP_APPEND_OTHER, 32'h0000_0005, 10'd0);
		send_item(OP_MERGE, 32'h0, 10'd0);
		send_item(OP_READ_OWN, 32'h0, 10'd0);
	endtask

	// Capacity at the 11-bit top: the depth limits it, short lists behave as usual
	task automatic test_wide_capacity();
		write_capacity(11'h7FF);
		send_item(OP_CLEAR, 32'h0, 10'd0);
		append_sorted(OP_APPEND_OWN, 12);
		append_sorted(OP_APPEND_OTHER, 10);
		send_item(OP_MERGE, 32'h0, 10'd0);
		read_some(3);
		send_item(OP_MERGE, 32'h0, 10'd0);
		send_item(OP_READ_OWN, 32'h0, 10'h3FF);
		send_item(OP_CLEAR, 32'h0, 10'd0);
	endtask

	// Random rounds over a spread of capacities, with idling on both sides
	task automatic test_random_merges();
		int unsigned start;
		start = live_items;
		while (live_items - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 5))
					0, 1:    write_capacity(11'($urandom_range(0, 4)));
					2, 3:    write_capacity(11'($urandom_range(5, 16)));
					4:       write_capacity(CAP_RESET);
					default: write_capacity(11'($urandom_range(DEPTH + 1, 2047)));
				endcase
			end
			run_merge_sequence();
		end
	endtask

	// Closing stretch with no idling: items and results move every cycle they can
	task automatic test_back_to_back();
		write_capacity(11'd12);
		idle_on = 1'b0;
		repeat (3) begin
			run_merge_sequence();
		end
	endtask

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------

	initial begin : stimulus
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_on = 1'b1;
		own_len = 0;
		other_len = 0;
		cap_setting = CAP_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_capacity_edges();
		test_wide_capacity();
		test_random_merges();
		test_back_to_back();

		wait_idle();
		$display("Covered %0d transactions (%0d live) and %0d results; %0d merges, %0d overflowed.",
			items_sent, live_items, results_seen, merges_sent, merge_overflows);
		$display("Capacity rewritten %0d times, from zero up to values past the memory depth.",
			cap_writes);
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/smrg_pkg.sv
rtl/smrg_ram.sv
rtl/sparse_key_sorted_merge.sv
tb/tb.sv
